// ===== hw/rtl/pwf_pkg.sv =====
// Package: shared types, register map, pixel modes and palette for the pixel write formatter.
package pwf_pkg;

	localparam int PALETTE_ENTRIES = 16;
	localparam int FIXED_COLORS    = 16;
	localparam int NUM_CELLS       = (PALETTE_ENTRIES < FIXED_COLORS) ?
		PALETTE_ENTRIES : FIXED_COLORS;
	localparam int IDX_W           = $clog2(NUM_CELLS);
	localparam int FIX_W           = $clog2(FIXED_COLORS);
	localparam int DIST_W          = 18;
	localparam int ADDR_W          = 5;

	localparam logic [DIST_W-1:0] NO_MATCH_DIST = '1;

	localparam logic [23:0] PALETTE [FIXED_COLORS] = '{
		24'h000000, 24'hFFFFFF, 24'h1A1F3A, 24'h101428,
		24'h6A82FB, 24'h404458, 24'h9090A0, 24'hC0C0C8,
		24'hF0F0F5, 24'h101018, 24'hE04040, 24'h40C060,
		24'h4253D4, 24'h6E82FF, 24'hE0E5F0, 24'h80A0FF
	};

	typedef enum logic [2:0] {
		REG_ENABLE        = 3'd0,
		REG_PIXEL_MODE    = 3'd1,
		REG_SCREEN_WIDTH  = 3'd2,
		REG_SCREEN_HEIGHT = 3'd3,
		REG_ROW_PITCH     = 3'd4,
		REG_BASE_ADDRESS  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_32BPP = 2'd0,
		MODE_24BPP = 2'd1,
		MODE_8BPP  = 2'd2
	} pixel_mode_t;

	localparam logic [2:0] BYTES_32BPP = 3'd4;
	localparam logic [2:0] BYTES_24BPP = 3'd3;
	localparam logic [2:0] BYTES_8BPP  = 3'd1;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        color;
	} pixel_in_t;

	typedef struct packed {
		logic        write_valid;
		logic [31:0] write_address;
		logic [31:0] write_data;
		logic [2:0]  write_bytes;
	} pixel_out_t;

	typedef struct packed {
		logic        enable;
		logic [1:0]  pixel_mode;
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [14:0] row_pitch;
		logic [31:0] base_address;
	} cfg_t;

	// One transaction as it travels along the palette cells.
	typedef struct packed {
		logic              valid;
		logic              write_valid;
		logic              indexed;
		logic [31:0]       address;
		logic [31:0]       data;
		logic [2:0]        bytes;
		logic [23:0]       rgb;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
	} link_t;

	function automatic logic [23:0] palette_color(input logic [IDX_W-1:0] idx);
		return PALETTE[FIX_W'(idx)];
	endfunction

endpackage

// ===== hw/rtl/pwf_front.sv =====
// Front end: clip test, mode decode and address arithmetic ahead of the palette cells.
module pwf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  pwf_pkg::pixel_in_t pixel,
	input  pwf_pkg::cfg_t      cfg,
	output pwf_pkg::link_t     head
);
	import pwf_pkg::*;

	logic        valid_s1, wr_s1, indexed_s1;
	logic [12:0] x_s1, y_s1;
	logic [2:0]  bytes_s1;
	logic [31:0] color_s1;

	logic        valid_s2, wr_s2, indexed_s2;
	logic [27:0] row_off_s2;
	logic [14:0] col_off_s2;
	logic [2:0]  bytes_s2;
	logic [31:0] color_s2;

	logic        hit;
	logic [2:0]  bytes_d;
	logic        indexed_d;
	logic [14:0] col_off_d;

	// Drop writes that are disabled or off screen; negative values fail the compare.
	assign hit = cfg.enable
		&& (unsigned'(pixel.pos_x) < {3'b000, cfg.screen_width})
		&& (unsigned'(pixel.pos_y) < {3'b000, cfg.screen_height});

	always_comb begin
		unique case (cfg.pixel_mode)
			MODE_32BPP: begin
				bytes_d   = BYTES_32BPP;
				indexed_d = 1'b0;
			end
			MODE_24BPP: begin
				bytes_d   = BYTES_24BPP;
				indexed_d = 1'b0;
			end
			default: begin
				bytes_d   = BYTES_8BPP;
				indexed_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		wr_s1      <= hit;
		indexed_s1 <= indexed_d;
		bytes_s1   <= bytes_d;
		x_s1       <= pixel.pos_x[12:0];
		y_s1       <= pixel.pos_y[12:0];
		color_s1   <= pixel.color;
	end

	always_comb begin
		case (bytes_s1)
			BYTES_32BPP: col_off_d = {x_s1, 2'b00};
			BYTES_24BPP: col_off_d = {2'b00, x_s1} + {1'b0, x_s1, 1'b0};
			default:     col_off_d = {2'b00, x_s1};
		endcase
	end

	always_ff @(posedge clk) begin
		wr_s2      <= wr_s1;
		indexed_s2 <= indexed_s1;
		bytes_s2   <= bytes_s1;
		color_s2   <= color_s1;
		row_off_s2 <= {15'd0, y_s1} * {13'd0, cfg.row_pitch};
		col_off_s2 <= col_off_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head <= '0;
		end else begin
			head.valid       <= valid_s2;
			head.write_valid <= wr_s2;
			head.indexed     <= indexed_s2;
			head.address     <= cfg.base_address + {4'd0, row_off_s2} + {17'd0, col_off_s2};
			head.data        <= indexed_s2 ? 32'd0 : ((bytes_s2 == BYTES_24BPP) ?
				{8'd0, color_s2[23:0]} : color_s2);
			head.bytes       <= bytes_s2;
			head.rgb         <= color_s2[23:0];
			head.best_idx    <= '0;
			head.best_dist   <= NO_MATCH_DIST;
		end
	end

endmodule

// ===== hw/rtl/pwf_cell.sv =====
// Palette cell: measures the distance to one palette entry and keeps the nearest so far.
module pwf_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pwf_pkg::IDX_W-1:0]  cell_index,
	input  pwf_pkg::link_t             link_in,
	output pwf_pkg::link_t             link_out
);
	import pwf_pkg::*;

	logic [23:0]       pal;
	logic [7:0]        dr, dg, db;
	logic [DIST_W-1:0] sq_dist;

	assign pal = palette_color(cell_index);

	always_comb begin
		dr = (link_in.rgb[23:16] > pal[23:16]) ? link_in.rgb[23:16] - pal[23:16]
			: pal[23:16] - link_in.rgb[23:16];
		dg = (link_in.rgb[15:8] > pal[15:8]) ? link_in.rgb[15:8] - pal[15:8]
			: pal[15:8] - link_in.rgb[15:8];
		db = (link_in.rgb[7:0] > pal[7:0]) ? link_in.rgb[7:0] - pal[7:0]
			: pal[7:0] - link_in.rgb[7:0];
		sq_dist = DIST_W'({8'd0, dr} * {8'd0, dr}) + DIST_W'({8'd0, dg} * {8'd0, dg})
			+ DIST_W'({8'd0, db} * {8'd0, db});
	end

	// Strictly closer only, so a tie keeps the lower index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_out <= '0;
		end else begin
			link_out.valid       <= link_in.valid;
			link_out.write_valid <= link_in.write_valid;
			link_out.indexed     <= link_in.indexed;
			link_out.address     <= link_in.address;
			link_out.data        <= link_in.data;
			link_out.bytes       <= link_in.bytes;
			link_out.rgb         <= link_in.rgb;
			if (sq_dist < link_in.best_dist) begin
				link_out.best_idx  <= cell_index;
				link_out.best_dist <= sq_dist;
			end else begin
				link_out.best_idx  <= link_in.best_idx;
				link_out.best_dist <= link_in.best_dist;
			end
		end
	end

endmodule

// ===== hw/rtl/pixel_write_formatter.sv =====
// Top level: pixel write formatter with APB register block and palette cell chain.
//
// Usage
//   Pixel writes enter on the command channel: a transaction is taken at a
//   rising edge with start high and busy low. busy is always low, so a new
//   pixel may be issued in every cycle; each pixel stands alone.
//   Each pixel yields exactly one result on the result port, marked by a
//   one-cycle done strobe. result.write_valid is low (and all other fields
//   zero) when the block is disabled or the point lies off screen.
//   The path is 20 register stages: three front stages (capture and clip,
//   multiply, address add), one stage per palette cell (16 cells, one
//   entry each) and the output register, which sets done and the result
//   together. Throughput is one pixel per cycle.
//   The receiver cannot hold results off; results are never stalled.
//   Registers are written over APB at byte address 4*index and read back
//   the same way; write them only while no pixel is in flight.
//   Reset clears all registers (block disabled) and empties the pipeline.
module pixel_write_formatter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  pwf_pkg::pixel_in_t               pixel,
	output logic                             done,
	output pwf_pkg::pixel_out_t              result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pwf_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import pwf_pkg::*;

	cfg_t       cfg_q;
	link_t      link [NUM_CELLS+1];
	reg_idx_t   reg_sel;
	logic       cfg_wr;
	pixel_out_t result_d;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Register block: decode on the word index, ignore indexes beyond the map.
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_ENABLE:        cfg_q.enable        <= pwdata[0];
				REG_PIXEL_MODE:    cfg_q.pixel_mode    <= pwdata[1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[12:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[12:0];
				REG_ROW_PITCH:     cfg_q.row_pitch     <= pwdata[14:0];
				REG_BASE_ADDRESS:  cfg_q.base_address  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ENABLE:        prdata = {31'd0, cfg_q.enable};
			REG_PIXEL_MODE:    prdata = {30'd0, cfg_q.pixel_mode};
			REG_SCREEN_WIDTH:  prdata = {19'd0, cfg_q.screen_width};
			REG_SCREEN_HEIGHT: prdata = {19'd0, cfg_q.screen_height};
			REG_ROW_PITCH:     prdata = {17'd0, cfg_q.row_pitch};
			REG_BASE_ADDRESS:  prdata = cfg_q.base_address;
			default:           prdata = 32'd0;
		endcase
	end

	// Front end: clip, decode mode and form the byte address.
	pwf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (start && !busy),
		.pixel  (pixel),
		.cfg    (cfg_q),
		.head   (link[0])
	);

	// Palette search: each cell owns one entry and hands the best match on.
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		pwf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (IDX_W'(i)),
			.link_in    (link[i]),
			.link_out   (link[i+1])
		);
	end

	// Output: zero every field of a dropped write, pick index or colour data.
	always_comb begin
		result_d = '0;
		if (link[NUM_CELLS].write_valid) begin
			result_d.write_valid   = 1'b1;
			result_d.write_address = link[NUM_CELLS].address;
			result_d.write_bytes   = link[NUM_CELLS].bytes;
			result_d.write_data    = link[NUM_CELLS].indexed ?
				32'(link[NUM_CELLS].best_idx) : link[NUM_CELLS].data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= link[NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		result <= result_d;
	end

endmodule
